// ===== rtl/olst_pkg.sv =====
package olst_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LIST   = 2'd2,
        CMD_SEARCH = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] item;
        logic               last;
    } t_out;

    typedef struct packed {
        logic shift;
        logic wrap;
        logic write;
    } t_cell_ctl;

    function automatic t_word to_word(input logic [31:0] v);
        logic [63:0] t;
        begin
            t = {32'd0, v};
            return t[DATA_WIDTH-1:0];
        end
    endfunction

    function automatic logic signed [31:0] to_item(input t_word w);
        logic signed [63:0] t;
        begin
            t = 64'(signed'(w));
            return t[31:0];
        end
    endfunction

endpackage

// ===== rtl/ordered_list_store.sv =====
// channel   direction  handshake                       payload
// in        input      i_in_valid / o_in_ready         i_in_data  (cmd, value)
// out       output     o_out_valid / i_out_ready       o_out_data (status, item, last)
//
// Append, and any command on an empty list, are answered from the idle state without a walk.
// Remove, search and list rotate the cell ring once per stored entry, walking one entry
// per cycle past the head cell while the output is not stalled.
// Reset clears the entry count and the output valid flag; entry cells are not cleared.
// A stalled output freezes the walk; a new transfer is taken only when idle and the
// output register is free or being drained.
module ordered_list_store (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  olst_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output olst_pkg::t_out  o_out_data
);
    import olst_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_n;
    logic [IDX_W-1:0] r_k;
    t_cmd             r_cmd;
    t_word            r_val;
    logic             r_found;
    logic             r_ovalid;
    t_out             r_out;

    t_word     cell_data [DEPTH];
    t_cell_ctl cell_ctl  [DEPTH];

    logic  out_free;
    logic  in_ready;
    logic  in_xfer;
    t_word head;
    t_word in_word;
    logic  match;
    logic  walk_adv;
    logic  last_step;
    logic  drop;
    logic  is_full;
    logic  app_ok;
    logic  out_load;

    always_comb begin
        out_free  = !r_ovalid || i_out_ready;
        in_ready  = (r_state == S_IDLE) && out_free;
        in_xfer   = i_in_valid && in_ready;
        head      = cell_data[0];
        in_word   = to_word(i_in_data.value);
        match     = (r_cmd != CMD_LIST) && !r_found && (head == r_val);
        walk_adv  = (r_state == S_WALK) && out_free;
        last_step = (CNT_W'(r_k) == (r_n - CNT_W'(1)));
        drop      = walk_adv && (r_cmd == CMD_REMOVE) && match;
        is_full   = (r_count == CNT_W'(DEPTH));
        app_ok    = in_xfer && (i_in_data.cmd == CMD_APPEND) && !is_full;
        out_load  = (in_xfer && ((i_in_data.cmd == CMD_APPEND) || (r_count == '0)))
                    || (walk_adv && ((r_cmd == CMD_LIST) || last_step));
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word next_data;

        if (g == DEPTH - 1) begin : g_tail
            assign next_data = cell_data[0];
        end else begin : g_mid
            assign next_data = cell_data[g+1];
        end

        assign cell_ctl[g].shift = walk_adv;
        assign cell_ctl[g].wrap  = !drop && (r_count == CNT_W'(g + 1));
        assign cell_ctl[g].write = app_ok && (r_count == CNT_W'(g));

        olst_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[g]),
            .i_next  (next_data),
            .i_head  (cell_data[0]),
            .i_wdata (in_word),
            .o_data  (cell_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= out_load || (r_ovalid && !i_out_ready);
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cmd   <= i_in_data.cmd;
                        r_val   <= in_word;
                        r_found <= 1'b0;
                        r_k     <= '0;
                        r_n     <= r_count;
                        if (i_in_data.cmd == CMD_APPEND) begin
                            r_out    <= '{status: (is_full ? ST_FULL : ST_OK),
                                          item: 32'sd0, last: 1'b1};
                            if (!is_full) begin
                                r_count <= r_count + CNT_W'(1);
                            end
                        end else if (r_count == '0) begin
                            r_out    <= '{status: ST_EMPTY, item: 32'sd0, last: 1'b1};
                        end else begin
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (walk_adv) begin
                        r_k <= r_k + IDX_W'(1);
                        if (match) begin
                            r_found <= 1'b1;
                        end
                        if (drop) begin
                            r_count <= r_count - CNT_W'(1);
                        end
                        if (r_cmd == CMD_LIST) begin
                            r_out    <= '{status: ST_OK, item: to_item(head),
                                          last: last_step};
                        end else if (last_step) begin
                            r_out    <= '{status: ((r_found || match) ? ST_OK : ST_NOT_FOUND),
                                          item: 32'sd0, last: 1'b1};
                        end
                        if (last_step) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/olst_cell.sv =====
module olst_cell (
    input  logic               i_clk,
    input  olst_pkg::t_cell_ctl i_ctl,
    input  olst_pkg::t_word    i_next,
    input  olst_pkg::t_word    i_head,
    input  olst_pkg::t_word    i_wdata,
    output olst_pkg::t_word    o_data
);
    import olst_pkg::*;

    t_word r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.write) begin
            r_data <= i_wdata;
        end else if (i_ctl.shift) begin
            r_data <= i_ctl.wrap ? i_head : i_next;
        end
    end

    assign o_data = r_data;

endmodule

// ===== tb/sv/ordered_list_store_tb.sv =====
`timescale 1ns / 100ps

module ordered_list_store_tb;
    import olst_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    t_word stored_words [DEPTH];
    int    stored_n;
    t_out  due_results [$];

    int fail_count;
    int idle_cycles;
    int tx_gap_pct;
    int rx_stall_pct;
    int rx_long_hold;

    ordered_list_store DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(40, 12);
        return $urandom_range(3, 1);
    endfunction

    function automatic logic signed [31:0] word_as_item(input t_word w);
        logic [63:0] wide;
        wide = {64{w[DATA_WIDTH-1]}};
        wide[DATA_WIDTH-1:0] = w;
        return wide[31:0];
    endfunction

    function automatic logic [31:0] corner_value(input int k);
        case (k % 7)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'hAAAA_AAAA;
            5: return 32'h5555_5555;
            default: return 32'h0000_0001;
        endcase
    endfunction

    function automatic void owe(input t_status s, input logic signed [31:0] it, input logic lst);
        t_out r;
        r.status = s;
        r.item   = it;
        r.last   = lst;
        due_results.push_back(r);
    endfunction

    function automatic void model_list_cmd(input t_in x);
        logic [63:0] wide;
        t_word       w;
        int          pos;
        wide = {32'd0, x.value};
        w    = wide[DATA_WIDTH-1:0];
        if (x.cmd == CMD_APPEND) begin
            if (stored_n >= DEPTH) begin
                owe(ST_FULL, '0, 1'b1);
            end else begin
                stored_words[stored_n] = w;
                stored_n++;
                owe(ST_OK, '0, 1'b1);
            end
        end else if (stored_n == 0) begin
            owe(ST_EMPTY, '0, 1'b1);
        end else if (x.cmd == CMD_LIST) begin
            for (int i = 0; i < stored_n; i++)
                owe(ST_OK, word_as_item(stored_words[i]), i == stored_n - 1);
        end else begin
            pos = stored_n;
            for (int i = stored_n - 1; i >= 0; i--)
                if (stored_words[i] == w) pos = i;
            if (pos == stored_n) begin
                owe(ST_NOT_FOUND, '0, 1'b1);
            end else begin
                if (x.cmd == CMD_REMOVE) begin
                    for (int i = pos; i + 1 < stored_n; i++)
                        stored_words[i] = stored_words[i + 1];
                    stored_n--;
                end
                owe(ST_OK, '0, 1'b1);
            end
        end
    endfunction

    task automatic send_cmd(input t_cmd c, input logic [31:0] v);
        t_in x;
        int  gap;
        x.cmd   = c;
        x.value = v;
        gap = pick_gap(tx_gap_pct);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_data  <= x;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        model_list_cmd(x);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_refusals();
        send_cmd(CMD_REMOVE, 32'h8000_0000);
        send_cmd(CMD_SEARCH, 32'h7FFF_FFFF);
        send_cmd(CMD_LIST, 32'hFFFF_FFFF);
    endtask

    task automatic test_fill_to_full();
        for (int i = 0; i < DEPTH; i++)
            send_cmd(CMD_APPEND, corner_value(i));
        send_cmd(CMD_APPEND, 32'h1234_5678);
        send_cmd(CMD_LIST, 32'h0);
    endtask

    task automatic test_match_rules();
        send_cmd(CMD_SEARCH, 32'h0000_0001);
        send_cmd(CMD_SEARCH, 32'h1234_5678);
        send_cmd(CMD_REMOVE, 32'h8000_0000);
        send_cmd(CMD_REMOVE, 32'h0000_0000);
        send_cmd(CMD_REMOVE, 32'h1234_5678);
        send_cmd(CMD_LIST, 32'h5555_5555);
    endtask

    task automatic test_output_backpressure();
        tx_gap_pct   = 0;
        rx_long_hold = LONG_HOLD;
        for (int i = 0; i < 10; i++)
            send_cmd((i % 2 == 0) ? CMD_LIST : CMD_SEARCH, corner_value(i));
    endtask

    task automatic test_pause_until_drained();
        wait_drained();
        repeat (2 * DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic test_random_mix(input int n, input int tx_pct, input int rx_pct,
                                   input int append_pct);
        int          r;
        t_cmd        c;
        logic [31:0] v;
        tx_gap_pct   = tx_pct;
        rx_stall_pct = rx_pct;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < append_pct) begin
                c = CMD_APPEND;
            end else begin
                case ($urandom_range(4))
                    0, 1:    c = CMD_REMOVE;
                    2, 3:    c = CMD_SEARCH;
                    default: c = CMD_LIST;
                endcase
            end
            r = $urandom_range(99);
            if (stored_n > 0 && r < 50)
                v = word_as_item(stored_words[$urandom_range(stored_n - 1)]);
            else if (r < 75)
                v = corner_value($urandom_range(6));
            else
                v = $urandom;
            send_cmd(c, v);
        end
    endtask

    initial begin : rx_side
        int hold;
        hold = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_long_hold > 0) begin
                hold         = rx_long_hold;
                rx_long_hold = 0;
            end else if (hold == 0) begin
                hold = pick_gap(rx_stall_pct);
            end
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                hold--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_out
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected transfer: status %0d item %0d last %0d",
                             o_out_data.status, o_out_data.item, o_out_data.last);
            end else begin
                want = due_results.pop_front();
                if (o_out_data.status !== want.status || o_out_data.item !== want.item
                        || o_out_data.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected status %0d item %0d last %0d, ",
                                 want.status, want.item, want.last,
                                 "got status %0d item %0d last %0d",
                                 o_out_data.status, o_out_data.item, o_out_data.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        fail_count   = 0;
        idle_cycles  = 0;
        stored_n     = 0;
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        rx_long_hold = 0;
        for (int i = 0; i < DEPTH; i++) stored_words[i] = '0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_refusals();
        test_fill_to_full();
        test_match_rules();
        test_output_backpressure();
        test_random_mix(40, 0, 0, 70);
        test_random_mix(40, 30, 30, 55);
        test_random_mix(40, 10, 50, 40);
        test_pause_until_drained();
        test_random_mix(40, 50, 10, 60);
        test_random_mix(40, 20, 20, 25);
        test_random_mix(40, 40, 40, 50);

        wait_drained();
        repeat (2 * DEPTH + 8) @(posedge i_clk);
        if (due_results.size() != 0) begin
            fail_count++;
            $display("%0d results never arrived", due_results.size());
        end
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/olst_pkg.sv
rtl/olst_cell.sv
rtl/ordered_list_store.sv
tb/sv/ordered_list_store_tb.sv
